### hw/rtl/lsr_pkg.sv
// Package for the line statistic reducer: sequencer states, codes and fixed widths.
`default_nettype none
package lsr_pkg;

  localparam int unsigned MAX_LINE_DEF = 4096;

  // Fixed widths that cover the whole parameter range.
  localparam int unsigned MULA_W = 48;   // wide multiplier operand
  localparam int unsigned MULB_W = 17;   // narrow multiplier operand
  localparam int unsigned MULP_W = MULA_W + MULB_W;
  localparam int unsigned MAG_W  = 32;   // magnitude of the line sum
  localparam int unsigned PROD_W = 48;   // saturated product, signed
  localparam int unsigned ACC_W  = 66;   // variance numerator
  localparam int unsigned NUM_W  = 82;   // dividend or radicand shift register
  localparam int unsigned DVS_W  = 34;   // divisor
  localparam int unsigned REM_W  = 44;   // partial remainder
  localparam int unsigned QUO_W  = 64;   // quotient or root
  localparam int unsigned CNT_W  = 7;    // iteration counter

  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(NUM_W - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(NUM_W / 2 - 1);

  localparam logic [MULP_W-1:0] PROD_POS_LIM = MULP_W'(64'h0000_7FFF_FFFF_FFFF);
  localparam logic [MULP_W-1:0] PROD_NEG_MAG = MULP_W'(64'h0000_8000_0000_0000);

  // Configuration register indexes.
  localparam logic REG_MEASURE = 1'b0;
  localparam logic REG_HONOR   = 1'b1;

  // Measure codes.
  localparam logic [3:0] M_MIN      = 4'd0;
  localparam logic [3:0] M_MAX      = 4'd1;
  localparam logic [3:0] M_MEAN     = 4'd2;
  localparam logic [3:0] M_PRODUCT  = 4'd3;
  localparam logic [3:0] M_SUM      = 4'd4;
  localparam logic [3:0] M_L1       = 4'd5;
  localparam logic [3:0] M_L2       = 4'd6;
  localparam logic [3:0] M_LINF     = 4'd7;
  localparam logic [3:0] M_VARIANCE = 4'd8;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_PROD,
    S_PRODW,
    S_END,
    S_V1,
    S_V2,
    S_V3,
    S_V4,
    S_V5,
    S_ITER,
    S_FIN,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

### hw/rtl/line_statistic_reducer_unit.sv
// Top level of the line statistic reducer: streaming reduction of a scanline to one statistic.
`default_nettype none
// The unit takes one signed 16-bit sample word per handshake and reduces a whole scanline,
// ended by last_sample, to one statistic chosen by measure_select, given as a signed Q.16
// word. A sample word that is counted and present passes through three sequencer steps
// (ACC, PROD, PRODW) before in_ready returns; they share one 48x17 multiplier for the
// square and the running product. A skipped or absent word passes through ACC alone.
// At line end min, max, product, sum, L1 and Linf take only the S_END and S_DONE steps;
// mean runs the shared restoring divider for 82 steps, L2 runs the same compare-subtract
// unit as a square root for 41 steps, and variance first spends four multiplier passes on
// its numerator and divisor before the 82 divider steps. The result sits in an output
// register, so the unit accepts the next line while the result waits; a further line end
// waits for that register to empty. Configuration writes take effect at once.
module line_statistic_reducer_unit #(
  parameter int unsigned MAX_LINE = lsr_pkg::MAX_LINE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [3:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] sample,
  input  wire logic               present,
  input  wire logic               last_sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [63:0]      value,
  output logic                    empty_res,
  output logic                    overflow
);
  import lsr_pkg::*;

  // Accumulator widths follow from the longest line that is still counted.
  localparam int unsigned CW   = $clog2(2 * MAX_LINE);
  localparam int unsigned SUMW = 16 + CW;
  localparam int unsigned ABSW = 15 + CW;
  localparam int unsigned SQW  = 30 + CW;
  localparam logic [CW-1:0] COUNT_LIMIT = CW'(2 * MAX_LINE - 1);

  state_t state, state_next;

  logic [3:0] measure_select;
  logic       honor_absent;

  // Captured word.
  logic signed [15:0] x;
  logic               x_pres;
  logic               x_last;

  // Line state.
  logic signed [15:0]       running_min;
  logic signed [15:0]       running_max;
  logic signed [SUMW-1:0]   running_sum;
  logic [ABSW-1:0]          abs_sum;
  logic [SQW-1:0]           square_sum;
  logic signed [PROD_W-1:0] running_product;
  logic                     product_saturated;
  logic [15:0]              max_abs;
  logic [CW-1:0]            item_count;
  logic [CW-1:0]            present_count;

  // Line end datapath.
  logic [MAG_W-1:0]  ms;
  logic [ACC_W-1:0]  acc;
  logic [NUM_W-1:0]  num;
  logic [DVS_W-1:0]  dvs;
  logic [REM_W-1:0]  rem;
  logic [QUO_W-1:0]  quot;
  logic [CNT_W-1:0]  iter_cnt;
  logic              sqrt_mode;
  logic [63:0]       res;
  logic              res_empty;
  logic              res_ovf;

  // Shared multiplier.
  logic [MULA_W-1:0] mul_a;
  logic [MULB_W-1:0] mul_b;
  logic [MULP_W-1:0] mul_p;

  logic [15:0]        ax;
  logic [PROD_W-1:0]  prod_mag;
  logic               prod_neg;
  logic [SUMW-1:0]    sum_mag;
  logic [REM_W-1:0]   step_a;
  logic [REM_W-1:0]   step_b;
  logic               step_ge;
  logic               out_free;

  assign ax       = x[15] ? 16'(-x) : 16'(x);
  assign prod_mag = running_product[PROD_W-1] ? PROD_W'(-running_product)
                                              : PROD_W'(running_product);
  assign prod_neg = running_product[PROD_W-1] ^ x[15];
  assign sum_mag  = running_sum[SUMW-1] ? SUMW'(-running_sum) : SUMW'(running_sum);
  assign out_free = !out_valid || out_ready;

  // One compare-subtract step, a quotient bit of the divider or a root bit of the square root.
  assign step_a  = sqrt_mode ? {rem[REM_W-3:0], num[NUM_W-1:NUM_W-2]}
                             : {rem[REM_W-2:0], num[NUM_W-1]};
  assign step_b  = sqrt_mode ? {quot[REM_W-3:0], 2'b01} : REM_W'(dvs);
  assign step_ge = step_a >= step_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_ACC: begin
        mul_a = MULA_W'(ax);
        mul_b = MULB_W'(ax);
      end
      S_PROD: begin
        mul_a = MULA_W'(prod_mag);
        mul_b = MULB_W'(ax);
      end
      S_V1: begin
        mul_a = MULA_W'(square_sum);
        mul_b = MULB_W'(present_count);
      end
      S_V2: begin
        mul_a = MULA_W'(ms);
        mul_b = ms[MULB_W-1:0];
      end
      S_V3: begin
        mul_a = MULA_W'(ms);
        mul_b = MULB_W'(ms[MAG_W-1:MULB_W]);
      end
      S_V4: begin
        mul_a = MULA_W'(present_count);
        mul_b = MULB_W'(present_count);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        if (item_count < COUNT_LIMIT && x_pres) begin
          state_next = S_PROD;
        end else if (x_last) begin
          state_next = S_END;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_PROD:  state_next = S_PRODW;
      S_PRODW: state_next = x_last ? S_END : S_IDLE;
      S_END: begin
        if (measure_select > M_VARIANCE || present_count == '0) begin
          state_next = S_DONE;
        end else begin
          case (measure_select)
            M_MEAN, M_L2: state_next = S_ITER;
            M_VARIANCE:   state_next = S_V1;
            default:      state_next = S_DONE;
          endcase
        end
      end
      S_V1: state_next = S_V2;
      S_V2: state_next = S_V3;
      S_V3: state_next = S_V4;
      S_V4: state_next = S_V5;
      S_V5: state_next = S_ITER;
      S_ITER: begin
        if (iter_cnt == (sqrt_mode ? SQRT_LAST : DIV_LAST)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      measure_select <= M_MIN;
      honor_absent   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MEASURE: measure_select <= cfg_data;
        REG_HONOR:   honor_absent   <= cfg_data[0];
        default:     measure_select <= measure_select;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      value     <= res;
      empty_res <= res_empty;
      overflow  <= res_ovf;
    end
  end

  // Line state and the line end datapath.
  always_ff @(posedge clk) begin
    if (rst || (state == S_DONE && out_free)) begin
      running_min       <= '0;
      running_max       <= '0;
      running_sum       <= '0;
      abs_sum           <= '0;
      square_sum        <= '0;
      running_product   <= PROD_W'(1);
      product_saturated <= 1'b0;
      max_abs           <= '0;
      item_count        <= '0;
      present_count     <= '0;
    end else begin
      case (state)
        S_ACC: begin
          if (item_count < COUNT_LIMIT) begin
            item_count <= item_count + CW'(1);
            if (x_pres) begin
              if (present_count == '0) begin
                running_min <= x;
                running_max <= x;
                max_abs     <= ax;
              end else begin
                if (x < running_min) running_min <= x;
                if (x > running_max) running_max <= x;
                if (ax > max_abs) max_abs <= ax;
              end
              running_sum   <= running_sum + SUMW'(x);
              abs_sum       <= abs_sum + ABSW'(ax);
              present_count <= present_count + CW'(1);
            end
          end
        end
        S_PROD: begin
          square_sum <= square_sum + SQW'(mul_p);
        end
        S_PRODW: begin
          if (x == '0) begin
            running_product   <= '0;
            product_saturated <= 1'b0;
          end else if (product_saturated ||
                       mul_p > (prod_neg ? PROD_NEG_MAG : PROD_POS_LIM)) begin
            running_product   <= prod_neg ? PROD_W'(PROD_NEG_MAG) : PROD_W'(PROD_POS_LIM);
            product_saturated <= 1'b1;
          end else begin
            running_product <= prod_neg ? PROD_W'(-mul_p) : PROD_W'(mul_p);
          end
        end
        default: begin
          running_min <= running_min;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      x      <= sample;
      x_pres <= honor_absent ? present : 1'b1;
      x_last <= last_sample;
    end
    case (state)
      S_END: begin
        res       <= '0;
        res_empty <= 1'b0;
        res_ovf   <= 1'b0;
        rem       <= '0;
        quot      <= '0;
        iter_cnt  <= '0;
        ms        <= MAG_W'(sum_mag);
        sqrt_mode <= (measure_select == M_L2);
        num       <= (measure_select == M_L2) ? NUM_W'({square_sum, 32'b0})
                                              : NUM_W'({sum_mag, 16'b0});
        dvs       <= DVS_W'(item_count);
        if (measure_select > M_VARIANCE || present_count == '0) begin
          res_empty <= 1'b1;
        end else begin
          case (measure_select)
            M_MIN:     res <= 64'(running_min) << 16;
            M_MAX:     res <= 64'(running_max) << 16;
            M_PRODUCT: begin
              res     <= {running_product, 16'b0};
              res_ovf <= product_saturated;
            end
            M_SUM:     res <= 64'(running_sum) << 16;
            M_L1:      res <= 64'(abs_sum) << 16;
            M_LINF:    res <= 64'(max_abs) << 16;
            default:   res <= '0;
          endcase
        end
      end
      S_V2: acc <= ACC_W'(mul_p);
      S_V3: acc <= acc - ACC_W'(mul_p);
      S_V4: acc <= acc - ACC_W'({mul_p, 17'b0});
      S_V5: begin
        dvs <= DVS_W'(mul_p);
        num <= {acc, 16'b0};
      end
      S_ITER: begin
        rem      <= step_ge ? step_a - step_b : step_a;
        quot     <= {quot[QUO_W-2:0], step_ge};
        num      <= sqrt_mode ? {num[NUM_W-3:0], 2'b00} : {num[NUM_W-2:0], 1'b0};
        iter_cnt <= iter_cnt + CNT_W'(1);
      end
      S_FIN: begin
        // Mean truncates toward zero, so the sign goes back on the magnitude quotient.
        if (measure_select == M_MEAN && running_sum[SUMW-1]) begin
          res <= -quot;
        end else begin
          res <= quot;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

endmodule
`default_nettype wire
